### rtl/core/fhbc_pkg.sv
// Package for the fp32 / half / bfloat16 converter.
// Holds request codes, format codes and the conversion functions; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package fhbc_pkg;

  typedef enum logic {
    REQ_NARROW = 1'b0,
    REQ_WIDEN  = 1'b1
  } req_type_t;

  typedef enum logic {
    FMT_HALF = 1'b0,
    FMT_BF16 = 1'b1
  } narrow_fmt_t;

  localparam logic [15:0] HALF_EXP_MASK  = 16'h7C00;
  localparam logic [15:0] HALF_SIGN_MASK = 16'h8000;
  localparam logic [9:0]  HALF_QNAN_BIT  = 10'h200;
  localparam logic [6:0]  BF16_QNAN_BIT  = 7'h40;

  // Single to half, truncating the mantissa toward zero; overflow gives infinity.
  function automatic logic [15:0] to_half(input logic [31:0] bits);
    logic        sign;
    logic [7:0]  e8;
    logic [22:0] mant;
    logic [9:0]  m;
    logic [23:0] sig;
    logic [4:0]  sh;
    logic [23:0] shifted;
    begin
      sign    = bits[31];
      e8      = bits[30:23];
      mant    = bits[22:0];
      m       = mant[22:13];
      sig     = {1'b1, mant};
      // Subnormal shift is 126 - e8 for e8 in 103..112.
      sh      = 5'(8'd126 - e8);
      shifted = sig >> sh;
      if (e8 == 8'hFF) begin
        if (mant != 23'd0 && m == 10'd0) m = HALF_QNAN_BIT;
        to_half = {sign, 5'h1F, m};
      end else if (e8 >= 8'd143) begin
        to_half = {sign, 15'h7C00};
      end else if (e8 >= 8'd113) begin
        to_half = {sign, 5'(e8 - 8'd112), m};
      end else if (e8 < 8'd103 || e8 == 8'd0) begin
        to_half = {sign, 15'd0};
      end else begin
        to_half = {sign, shifted[14:0]};
      end
    end
  endfunction

  function automatic logic [15:0] to_bf16(input logic [31:0] bits);
    logic [15:0] r;
    begin
      r = bits[31:16];
      if (bits[30:23] == 8'hFF && bits[22:0] != 23'd0 && r[6:0] == 7'd0)
        r[6:0] = BF16_QNAN_BIT;
      to_bf16 = r;
    end
  endfunction

  // Half to single; subnormals normalized with a leading-zero count.
  function automatic logic [31:0] from_half(input logic [15:0] h);
    logic       sign;
    logic [4:0] e5;
    logic [9:0] mant;
    logic [3:0] lz;
    logic [9:0] norm;
    begin
      sign = h[15];
      e5   = h[14:10];
      mant = h[9:0];
      lz   = 4'd0;
      for (int i = 0; i < 10; i++) begin
        if (mant[i]) lz = 4'(9 - i);
      end
      norm = 10'(mant << (lz + 4'd1));
      if (e5 == 5'd0) begin
        if (mant == 10'd0) from_half = {sign, 31'd0};
        else from_half = {sign, 8'(8'd112 - {4'd0, lz}), norm, 13'd0};
      end else if (e5 == 5'h1F) begin
        from_half = {sign, 8'hFF, mant, 13'd0};
      end else begin
        from_half = {sign, 8'({3'd0, e5} + 8'd112), mant, 13'd0};
      end
    end
  endfunction

endpackage
`default_nettype wire

### rtl/core/fp32_half_bfloat_converter_top.sv
// Top level of the fp32 / half / bfloat16 converter.
// Depends on fhbc_pkg and fhbc_convert.
`timescale 1ns / 1ps
`default_nettype none
//
//  channel | direction | handshake          | payload
//  in_     | request   | in_valid/in_ready  | in_req_type, in_value_in, in_last_in
//  out_    | result    | out_valid/out_ready| out_value_out, out_last_out
//  cfg_    | write     | cfg_valid/cfg_ready| cfg_data (narrow_format)
//
// Each request is held in an input register, converted by one pass of bit
// logic, and caught in a result register. Each register advances when it is
// empty or the stage after it moves, so one request enters per cycle while
// the result side keeps up. Reset clears the valid flags and selects half
// precision. When the result side stalls, the pipeline holds and input ready
// drops only once both stages are full.
module fp32_half_bfloat_converter_top import fhbc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_req_type,
  input  wire logic [31:0] in_value_in,
  input  wire logic        in_last_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] out_value_out,
  output logic             out_last_out,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data
);
  logic        fmt_r;
  logic        s1_valid_r;
  logic        s1_req_r;
  logic [31:0] s1_value_r;
  logic        s1_last_r;
  logic        s2_valid_r;
  logic [31:0] s2_value_r;
  logic        s2_last_r;
  logic [31:0] conv_value;
  logic        s2_adv;
  logic        s1_adv;

  // The result stage moves whenever it is empty or being taken.
  assign s2_adv    = !s2_valid_r || out_ready;
  assign s1_adv    = !s1_valid_r || s2_adv;
  assign in_ready  = s1_adv;
  assign cfg_ready = 1'b1;

  fhbc_convert u_convert (
    .req_type (s1_req_r),
    .fmt      (fmt_r),
    .value_in (s1_value_r),
    .value_out(conv_value)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r      <= FMT_HALF;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) fmt_r <= cfg_data;
      if (s1_adv) s1_valid_r <= in_valid;
      if (s2_adv) s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_req_r   <= in_req_type;
      s1_value_r <= in_value_in;
      s1_last_r  <= in_last_in;
    end
    if (s2_adv) begin
      s2_value_r <= conv_value;
      s2_last_r  <= s1_last_r;
    end
  end

  assign out_valid     = s2_valid_r;
  assign out_value_out = s2_value_r;
  assign out_last_out  = s2_last_r;
endmodule
`default_nettype wire

### rtl/core/fhbc_convert.sv
// Combinational conversion datapath of the converter.
// Depends on fhbc_pkg for codes and conversion functions.
`timescale 1ns / 1ps
`default_nettype none
module fhbc_convert import fhbc_pkg::*; (
  input  wire logic        req_type,
  input  wire logic        fmt,
  input  wire logic [31:0] value_in,
  output logic      [31:0] value_out
);
  always_comb begin
    if (req_type == REQ_NARROW) begin
      value_out = {16'd0, (fmt == FMT_BF16) ? to_bf16(value_in) : to_half(value_in)};
    end else if (fmt == FMT_BF16) begin
      value_out = {value_in[15:0], 16'd0};
    end else begin
      value_out = from_half(value_in[15:0]);
    end
  end
endmodule
`default_nettype wire

### rtl/core/fhbc_checker.sv
// Port-level checker for the converter top level, with its bind.
// Depends on fp32_half_bfloat_converter_top.
`timescale 1ns / 1ps
`default_nettype none
module fhbc_port_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] out_value_out
);
  // A stalled result keeps its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value_out))
    else $error("result changed while stalled");
  // An accepted request shows up as a result while the output keeps taking results.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && out_ready ##1 out_ready |=> out_valid)
    else $error("result missing");
  // Input is refused only while a result is waiting.
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without stall");
  // No result appears out of reset.
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result after reset");
endmodule

bind fp32_half_bfloat_converter_top fhbc_port_checker u_fhbc_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_value_out(out_value_out)
);
`default_nettype wire

### tb/fhbc_checker.sv
// Checker for the fp32 / half / bfloat16 converter: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on fhbc_pkg for the request and format codes.
`timescale 1ns / 1ps
module fhbc_checker import fhbc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_req_type,
  input  logic [31:0] in_value_in,
  input  logic        in_last_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] out_value_out,
  input  logic        out_last_out,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  output int          fail_count,
  output int          pending
);
  typedef struct packed {
    logic [31:0] value;
    logic        last;
  } conv_result_t;

  conv_result_t expected_q[$];
  narrow_fmt_t  fmt;

  function automatic logic [15:0] narrow_to_half(logic [31:0] b);
    logic [15:0] s;
    int          e;
    logic [9:0]  m;
    int          sh;
    s = {b[31], 15'd0};
    e = int'(b[30:23]) - 127;
    if (b[30:23] == 8'hFF) begin
      m = b[22:13];
      if (b[22:0] != 0 && m == 0) m = 10'h200;
      return s | 16'h7C00 | {6'd0, m};
    end
    if (e >= 16) return s | 16'h7C00;
    if (e >= -14) return s | 16'((e + 15) << 10) | {6'd0, b[22:13]};
    sh = -e - 1;
    if (sh >= 24 || b[30:23] == 0) return s;
    return s | 16'(({1'b1, b[22:0]}) >> sh);
  endfunction

  function automatic logic [31:0] widen_half(logic [15:0] h);
    logic [31:0] s;
    logic [10:0] m;
    int          n;
    s = {h[15], 31'd0};
    m = {1'b0, h[9:0]};
    n = 0;
    if (h[14:10] == 0) begin
      if (m == 0) return s;
      while (!m[10]) begin
        m = m << 1;
        n++;
      end
      return s | (32'(113 - n) << 23) | ({22'd0, m[9:0]} << 13);
    end
    if (h[14:10] == 5'h1F) return s | 32'h7F800000 | ({22'd0, h[9:0]} << 13);
    return s | (32'(h[14:10] + 112) << 23) | ({22'd0, h[9:0]} << 13);
  endfunction

  function automatic logic [31:0] convert(logic req, logic [31:0] v);
    logic [15:0] r;
    if (req == REQ_NARROW) begin
      if (fmt == FMT_BF16) begin
        r = v[31:16];
        if (v[30:23] == 8'hFF && v[22:0] != 0 && r[6:0] == 0) r[6:0] = 7'h40;
        return {16'd0, r};
      end
      return {16'd0, narrow_to_half(v)};
    end
    if (fmt == FMT_BF16) return {v[15:0], 16'd0};
    return widen_half(v[15:0]);
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    conv_result_t got, want;
    int           errs;
    errs = 0;
    if (!rst_n) begin
      fmt <= FMT_HALF;
      fail_count <= 0;
    end else begin
      // Outputs are checked before this edge's request is queued; a request
      // cannot reach the output in the same cycle it is accepted.
      if (out_valid && out_ready) begin
        got = '{out_value_out, out_last_out};
        if (expected_q.size() == 0) begin
          $error("unexpected result value_out=%h", out_value_out);
          errs++;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value) begin
            $error("value_out expected %h actual %h", want.value, got.value);
            errs++;
          end
          if (got.last !== want.last) begin
            $error("last_out expected %b actual %b", want.last, got.last);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (in_valid && in_ready)
        expected_q.push_back('{convert(in_req_type, in_value_in), in_last_in});
      if (cfg_valid && cfg_ready) fmt <= narrow_fmt_t'(cfg_data);
    end
  end
endmodule

### tb/tb_fp32_half_bfloat_converter_top.sv
// Testbench top for the fp32 / half / bfloat16 converter: makes requests,
// register writes and back-pressure, and gives the verdict.
// Depends on fhbc_pkg, the block and fhbc_checker.
`timescale 1ns / 1ps
module tb_fp32_half_bfloat_converter_top;
  import fhbc_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_req_type = 1'b0;
  logic [31:0] in_value_in = '0;
  logic        in_last_in = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_value_out;
  logic        out_last_out;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  int          fail_count;
  int          pending;

  // Idle and stall rates in percent; the stall override forces a long hold-off.
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_cycles = 0;
  longint cycle_count = 0;

  always #6 clk = ~clk;

  fp32_half_bfloat_converter_top dut (.*);

  fhbc_checker u_checker (.*);

  // Cycle limit: generous against about 1100 requests at 84% idle and stall.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // The receiver stalls at random, and during a hold-off it stalls outright,
  // counting the stretch down in its own process.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Offer one request and hold it until the block accepts it. Valid stays
  // high afterwards so the next request can follow without a gap; idling or
  // draining drops it.
  task automatic send_request(logic req, logic [31:0] v, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= req;
    in_value_in <= v;
    in_last_in <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Register writes happen only once every outstanding result has arrived.
  task automatic write_format(narrow_fmt_t f);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random value that favors exponents near the half and bfloat boundaries.
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(5))
      0: v[30:23] = 8'(85 + $urandom_range(62));
      1: v[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      2: v[14:10] = $urandom_range(1) ? 5'h1F : 5'h00;
      3: v[22:13] = 10'd0;
      default: ;
    endcase
    return v;
  endfunction

  task automatic random_phase(int n, int idle, int stall);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    repeat (n) send_request(1'($urandom_range(1)), pick_value(), 1'($urandom_range(1)));
  endtask

  logic [31:0] directed[$] = '{
    32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h807F_FFFF, 32'h7F80_0000,
    32'hFF80_0000, 32'h7F80_0001, 32'h7F80_2000, 32'hFFC0_0000, 32'h4780_0000,
    32'h477F_FFFF, 32'h3880_0000, 32'h387F_FFFF, 32'h3380_0000, 32'h3300_0000,
    32'h3F80_0000, 32'hFFFF_FFFF, 32'h0000_7C01, 32'hFFFF_03FF, 32'h0000_0001,
    32'h0000_8200, 32'hABCD_3C00
  };

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed: every value both ways in both formats, reset format first.
    foreach (directed[i]) send_request(REQ_NARROW, directed[i], i[0]);
    foreach (directed[i]) send_request(REQ_WIDEN, directed[i], ~i[0]);
    write_format(FMT_BF16);
    foreach (directed[i]) send_request(REQ_NARROW, directed[i], i[0]);
    foreach (directed[i]) send_request(REQ_WIDEN, directed[i], i[1]);
    // Random phases under each idle pattern, alternating the format.
    write_format(FMT_HALF);
    random_phase(150, 0, 0);
    random_phase(150, 84, 0);
    write_format(FMT_BF16);
    random_phase(150, 0, 84);
    random_phase(150, 25, 25);
    write_format(FMT_HALF);
    random_phase(100, 0, 84);
    random_phase(100, 25, 25);
    // Long receiver hold-off while requests keep coming so the input stalls.
    hold_cycles = 60;
    random_phase(40, 0, 0);
    // Sender pauses until every result has come back.
    wait_drained();
    write_format(FMT_BF16);
    random_phase(100, 84, 0);
    random_phase(60, 0, 0);
    wait_drained();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
